/* hw/rtl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared widths, codes and structures of the sorted timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

	localparam int DEPTH    = 128;
	localparam int TAG_BITS = 16;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DL_W   = 48;
	localparam int NOW_W  = 47;
	localparam int DLY_W  = 32;
	localparam int TAGF_W = 16;
	localparam int SLOT_W = 7;
	localparam int POS_W  = 7;
	localparam int PEND_W = 8;
	localparam int SEL_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	localparam int IN_W  = 104;
	localparam int OUT_W = 88;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [DL_W-1:0]     dl;
		logic [TAG_BITS-1:0] tag;
	} stq_entry_t;

	typedef struct packed {
		logic                ins_en;
		logic                rem_en;
		logic [DL_W-1:0]     key;
		logic [TAG_BITS-1:0] tag;
		logic [SEL_W-1:0]    count;
		logic [SEL_W-1:0]    slot;
	} stq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/stq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one entry, compares it with the key and shifts with its neighbours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stq_cell import stq_pkg::*; (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	input  wire stq_cmd_t         cmd,
	input  wire stq_entry_t       left,
	input  wire stq_entry_t       right,
	input  wire logic             prev_le,
	output logic                  le,
	output stq_entry_t            entry
);

	stq_entry_t entry_q;
	logic       occupied;

	always_comb begin
		occupied = SEL_W'(idx) < cmd.count;
		le       = occupied && (entry_q.dl <= cmd.key);
		entry    = entry_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (!le) begin
				if (prev_le) begin
					entry_q.dl  <= cmd.key;
					entry_q.tag <= cmd.tag;
				end else begin
					entry_q <= left;
				end
			end
		end else if (cmd.rem_en) begin
			if (SEL_W'(idx) >= cmd.slot) begin
				entry_q <= right;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sorted_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue
// Keeps pending timers sorted by deadline in a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel and each gives exactly one result on the
// m_ channel. An insert places a timer after every entry with an equal or
// earlier deadline, a remove takes out the entry at a position and closes the
// gap, and a query reports the time left until the earliest deadline.
// An accepted transaction is registered with its deadline sum; then every
// cell compares its deadline with it and shifts
// in parallel, and the result is registered. The result is valid from the
// clock edge that follows the accepting edge, one cycle later, and a new
// request may be taken in every cycle, because the request register is freed
// as the cell row executes.
// While the receiver stalls, the result waits in the output register, one
// further request waits in the request register, and s_tready falls.
// Reset empties the queue and clears both channels; entry contents are not
// cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue_top import stq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// op[1:0], now_ms[48:2], delay_ms[80:49], tag[96:81], slot[103:97]
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status[1:0], position[8:2], remaining_ms[56:9], removed_tag[72:57],
	// pending[80:73]
	output logic [OUT_W-1:0]      m_tdata
);

	logic                req_vld_s1;
	op_t                 op_s1;
	logic [DL_W-1:0]     key_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [SEL_W-1:0]    slot_s1;
	logic [SEL_W-1:0]    count_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                accept;
	logic                exec;
	logic                full;
	logic                slot_ok;
	logic [NOW_W-1:0]    in_now;
	logic [DLY_W-1:0]    in_delay;
	op_t                 in_op;
	logic [DL_W-1:0]     in_key;

	stq_cmd_t            cmd;
	stq_entry_t          entries [DEPTH];
	logic                le      [DEPTH];
	logic [DEPTH-1:0]    ins_hit;
	logic [IDX_W-1:0]    ins_pos;
	logic [TAG_BITS-1:0] sel_tag;
	logic [DL_W-1:0]     remaining;
	status_t             status;
	logic [POS_W-1:0]    position;
	logic [DL_W-1:0]     rem_out;
	logic [TAGF_W-1:0]   rtag_out;
	logic [SEL_W-1:0]    count_d;

	always_comb begin
		in_op    = op_t'(s_tdata[1:0]);
		in_now   = s_tdata[48:2];
		in_delay = s_tdata[80:49];
		if (in_op == OP_INSERT && !in_delay[DLY_W-1]) begin
			in_key = DL_W'(in_now) + DL_W'(in_delay[DLY_W-2:0]);
		end else begin
			in_key = DL_W'(in_now);
		end
	end

	assign exec     = req_vld_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !req_vld_s1 || exec;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == SEL_W'(DEPTH);
	assign slot_ok  = slot_s1 < count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (accept) begin
			req_vld_s1 <= 1'b1;
		end else if (exec) begin
			req_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= in_op;
			key_s1  <= in_key;
			tag_s1  <= TAG_BITS'(s_tdata[96:81]);
			slot_s1 <= SEL_W'(s_tdata[103:97]);
		end
	end

	always_comb begin
		cmd.ins_en = exec && op_s1 == OP_INSERT && !full;
		cmd.rem_en = exec && op_s1 == OP_REMOVE && slot_ok;
		cmd.key    = key_s1;
		cmd.tag    = tag_s1;
		cmd.count  = count_q;
		cmd.slot   = slot_s1;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		stq_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(i)),
			.cmd     (cmd),
			.left    ((i == 0) ? entries[0] : entries[(i == 0) ? 0 : i - 1]),
			.right   ((i == DEPTH - 1) ? entries[i] : entries[(i == DEPTH - 1) ? i : i + 1]),
			.prev_le ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
			.le      (le[i]),
			.entry   (entries[i])
		);
		assign ins_hit[i] = !le[i] && ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]);
	end

	always_comb begin
		ins_pos = '0;
		sel_tag = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (ins_hit[i]) begin
				ins_pos = ins_pos | IDX_W'(i);
			end
			if (SEL_W'(i) == slot_s1) begin
				sel_tag = sel_tag | entries[i].tag;
			end
		end
		if (entries[0].dl > key_s1) begin
			remaining = entries[0].dl - key_s1;
		end else begin
			remaining = '0;
		end
	end

	always_comb begin
		status   = ST_OK;
		position = '0;
		rem_out  = '0;
		rtag_out = '0;
		count_d  = count_q;
		unique case (op_s1)
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					position = POS_W'(ins_pos);
					count_d  = count_q + SEL_W'(1);
				end
			end
			OP_REMOVE: begin
				if (!slot_ok) begin
					status = ST_BAD_INDEX;
				end else begin
					rtag_out = TAGF_W'(sel_tag);
					count_d  = count_q - SEL_W'(1);
				end
			end
			OP_QUERY: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					rem_out = remaining;
				end
			end
			OP_NONE: begin
				status = ST_OK;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (exec) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			m_tdata_q <= {7'd0, PEND_W'(count_d), rtag_out, rem_out, position, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SEL_W'(DEPTH))
		else $error("Entry count exceeds the queue depth.");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + SEL_W'(1))
		else $error("An accepted insert did not grow the count by one.");

	a_insert_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |-> $onehot(ins_hit))
		else $error("Insert position is not unique.");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> m_tvalid_q)
		else $error("An executed transaction gave no result.");

endmodule

`default_nettype wire

/* verif/tb_sorted_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives insert, remove and query requests into the sorted timer queue and
// checks every reply against a behavioural model of the deadline-ordered list.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty, bad index and clamped delay
// cases, ties and the widest deadlines. Random traffic then alternates
// between filling the list to capacity and draining it, while both sides of
// the stream idle at varying rates, the receiver holds off for a long spell
// and the sender twice waits for the block to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_timer_queue_top;
	import stq_pkg::*;

	localparam int LIMIT        = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 1630;

	typedef struct {
		op_t                 op;
		logic [NOW_W-1:0]    now;
		logic [DLY_W-1:0]    delay;
		logic [TAGF_W-1:0]   tag;
		logic [SLOT_W-1:0]   slot;
		bit                  drain_first;
	} request_t;

	typedef struct {
		status_t             status;
		logic [POS_W-1:0]    position;
		logic [DL_W-1:0]     remaining;
		logic [TAGF_W-1:0]   removed;
		logic [PEND_W-1:0]   pending;
	} reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// op[1:0], now_ms[48:2], delay_ms[80:49], tag[96:81], slot[103:97]
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// status[1:0], position[8:2], remaining_ms[56:9], removed_tag[72:57],
	// pending[80:73]
	logic [OUT_W-1:0]  m_tdata;

	request_t          pending_requests[$];
	reply_t            expected_replies[$];

	logic [DL_W-1:0]   timer_deadline[DEPTH];
	logic [TAGF_W-1:0] timer_tag[DEPTH];
	int                timer_count = 0;

	int                gen_count = 0;
	int                total = 0;
	int                sent = 0;
	int                errors = 0;
	int                cycles = 0;
	int                hold_left = 0;
	bit                hold_done = 1'b0;

	sorted_timer_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Applies one request to the model list and returns the reply it gives.
	function automatic reply_t timer_list_step(logic [IN_W-1:0] word);
		op_t              op;
		logic [NOW_W-1:0] now;
		logic [DLY_W-1:0] dly;
		logic [TAGF_W-1:0] tg;
		int               slot;
		logic [DL_W-1:0]  dl;
		int               pos;
		int               i;
		reply_t           r;
		op = op_t'(word[1:0]);
		now = word[48:2];
		dly = word[80:49];
		tg = word[96:81];
		slot = int'(word[103:97]);
		r.status = ST_OK;
		r.position = '0;
		r.remaining = '0;
		r.removed = '0;
		case (op)
			OP_INSERT: begin
				if (timer_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dl = {1'b0, now} + (dly[DLY_W-1] ? {DL_W{1'b0}} : {16'd0, dly});
					pos = 0;
					while (pos < timer_count && timer_deadline[pos] <= dl)
						pos++;
					for (i = timer_count; i > pos; i--) begin
						timer_deadline[i] = timer_deadline[i-1];
						timer_tag[i] = timer_tag[i-1];
					end
					timer_deadline[pos] = dl;
					timer_tag[pos] = tg;
					timer_count++;
					r.position = pos[POS_W-1:0];
				end
			end
			OP_REMOVE: begin
				if (slot >= timer_count) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.removed = timer_tag[slot];
					for (i = slot; i + 1 < timer_count; i++) begin
						timer_deadline[i] = timer_deadline[i+1];
						timer_tag[i] = timer_tag[i+1];
					end
					timer_count--;
				end
			end
			OP_QUERY: begin
				if (timer_count == 0)
					r.status = ST_EMPTY;
				else if (timer_deadline[0] > {1'b0, now})
					r.remaining = timer_deadline[0] - {1'b0, now};
			end
			default: begin
			end
		endcase
		r.pending = timer_count[PEND_W-1:0];
		return r;
	endfunction

	// Queues one request and tracks the count the block will hold after it.
	function automatic void add_request(op_t op, logic [NOW_W-1:0] now,
			logic [DLY_W-1:0] dly, logic [TAGF_W-1:0] tg, logic [SLOT_W-1:0] sl);
		request_t q;
		q.op = op;
		q.now = now;
		q.delay = dly;
		q.tag = tg;
		q.slot = sl;
		q.drain_first = 1'b0;
		pending_requests.push_back(q);
		if (op == OP_INSERT && gen_count < DEPTH)
			gen_count++;
		else if (op == OP_REMOVE && sl < gen_count)
			gen_count--;
	endfunction

	task automatic check_field(string name, logic [DL_W-1:0] want, logic [DL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		int       tx_pct;
		bit       go;
		request_t q;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				sent <= sent + 1;
			if (!s_tvalid || s_tready) begin
				tx_pct = (sent < total / 3) ? 31 : (sent < 2 * total / 3) ? 83 : 0;
				go = pending_requests.size() > 0 && $urandom_range(0, 99) >= tx_pct;
				if (go && pending_requests[0].drain_first &&
						(expected_replies.size() != 0 || (s_tvalid && s_tready)))
					go = 1'b0;
				if (go) begin
					q = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {q.slot, q.tag, q.delay, q.now, q.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		int rx_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent >= 2 * total / 3 + 40) begin
			// Long stall so that the block fills and back-pressures its input.
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rx_pct = (sent < total / 3) ? 83 : (sent < 2 * total / 3) ? 31 : 0;
			m_tready <= $urandom_range(0, 99) >= rx_pct;
		end
	end

	always @(posedge clk) begin : monitor
		reply_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					check_field("status", DL_W'(want.status), DL_W'(m_tdata[1:0]));
					check_field("position", DL_W'(want.position), DL_W'(m_tdata[8:2]));
					check_field("remaining_ms", want.remaining, m_tdata[56:9]);
					check_field("removed_tag", DL_W'(want.removed), DL_W'(m_tdata[72:57]));
					check_field("pending", DL_W'(want.pending), DL_W'(m_tdata[80:73]));
				end
			end
			if (s_tvalid && s_tready)
				expected_replies.push_back(timer_list_step(s_tdata));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("sorted_timer_queue_top: mismatch");
			$finish;
		end
	end

	initial begin
		logic [NOW_W-1:0]  now_max;
		logic [NOW_W-1:0]  time_base;
		logic [NOW_W-1:0]  now;
		logic [DLY_W-1:0]  dly;
		logic [SLOT_W-1:0] sl;
		op_t               op;
		bit                filling;
		int                r;
		now_max = {NOW_W{1'b1}};
		time_base = '0;
		filling = 1'b1;

		add_request(OP_QUERY, '0, '0, '0, '0);
		add_request(OP_REMOVE, '0, '0, '0, '0);
		add_request(OP_NONE, now_max, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F);
		add_request(OP_INSERT, '0, '0, 16'h0000, '0);
		add_request(OP_INSERT, '0, '0, 16'hFFFF, 7'h7F);
		add_request(OP_INSERT, now_max, 32'h7FFF_FFFF, 16'h1234, '0);
		add_request(OP_INSERT, 47'd100, 32'hFFFF_FFFF, 16'h00FF, '0);
		add_request(OP_INSERT, 47'd100, 32'h8000_0000, 16'hFF00, '0);
		add_request(OP_QUERY, '0, '0, '0, '0);
		add_request(OP_REMOVE, '0, '0, '0, 7'd0);
		add_request(OP_REMOVE, '0, '0, '0, 7'd127);
		add_request(OP_REMOVE, '0, '0, '0, 7'd4);
		add_request(OP_REMOVE, '0, '0, '0, 7'd3);
		add_request(OP_REMOVE, '0, '0, '0, 7'd0);
		add_request(OP_QUERY, 47'd40, '0, '0, '0);
		add_request(OP_QUERY, now_max, '0, '0, '0);
		add_request(OP_INSERT, 47'd50, 32'd50, 16'h5A5A, '0);
		add_request(OP_REMOVE, '0, '0, '0, 7'd1);
		add_request(OP_REMOVE, '0, '0, '0, 7'd0);
		add_request(OP_REMOVE, '0, '0, '0, 7'd0);
		add_request(OP_QUERY, '0, '0, '0, '0);
		add_request(OP_NONE, '0, '0, '0, '0);

		// Alternate between filling the list past capacity and draining it.
		repeat (RANDOM_ITEMS) begin
			time_base = NOW_W'(time_base + $urandom_range(0, 40));
			r = $urandom_range(0, 99);
			now = (r < 6) ? NOW_W'({$urandom, $urandom}) : (r < 8) ? now_max : time_base;
			r = $urandom_range(0, 99);
			if (r < 55)
				dly = $urandom_range(0, 2000);
			else if (r < 70)
				dly = '0;
			else if (r < 85)
				dly = $urandom | 32'h8000_0000;
			else
				dly = $urandom;
			if (gen_count > 0 && $urandom_range(0, 99) < 85)
				sl = SLOT_W'($urandom_range(0, gen_count - 1));
			else
				sl = SLOT_W'($urandom_range(0, 127));
			r = $urandom_range(0, 99);
			if (filling)
				op = (r < 82) ? OP_INSERT : (r < 90) ? OP_REMOVE : (r < 97) ? OP_QUERY : OP_NONE;
			else
				op = (r < 78) ? OP_REMOVE : (r < 88) ? OP_INSERT : (r < 97) ? OP_QUERY : OP_NONE;
			add_request(op, now, dly, 16'($urandom), sl);
			if (filling && gen_count == DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && gen_count == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
		end
		pending_requests[500].drain_first = 1'b1;
		pending_requests[1300].drain_first = 1'b1;
		total = pending_requests.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (sent < total)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("sorted_timer_queue_top: match");
		else
			$display("sorted_timer_queue_top: mismatch");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_queue_top.sv
verif/tb_sorted_timer_queue_top.sv
